FILE: rtl/core/dctd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dctd_pkg: shared types and constants of the task dispatcher
// Beat layouts, status and function codes, configuration register map.
// ----------------------------------------------------------------------------
package dctd_pkg;

  localparam int unsigned NUM_SETS_DEF    = 8;
  localparam int unsigned ACTION_BITS_DEF = 4;

  localparam int unsigned MAX_SETS   = 8;   // set ids are three bits wide
  localparam int unsigned SET_W      = 3;
  localparam int unsigned FIELD_W    = 4;   // packed per-set counter fields
  localparam int unsigned MASK_W     = 8;   // per-set successor mask
  localparam int unsigned ACT_W      = 4;   // granted action index
  localparam int unsigned POS_W      = 4;   // order position / order length
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef enum logic [2:0] {
    ST_GRANTED  = 3'd0,
    ST_BLOCKED  = 3'd1,
    ST_ALL_DONE = 3'd2,
    ST_ACCEPTED = 3'd3,
    ST_EXCESS   = 3'd4
  } status_e;

  typedef enum logic {
    FUNC_REQUEST = 1'b0,
    FUNC_FINISH  = 1'b1
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTION_COUNTS    = 3'd0,
    CFG_INITIAL_BLOCKERS = 3'd1,
    CFG_SUCCESSOR_MASKS  = 3'd2,
    CFG_DISPATCH_ORDER   = 3'd3,
    CFG_ORDER_LENGTH     = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic             func;
    logic [SET_W-1:0] finished_set;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic [SET_W-1:0] granted_set;
    logic [ACT_W-1:0] granted_action;
  } out_t;

  typedef struct packed {
    logic [31:0]      action_counts;
    logic [31:0]      initial_blockers;
    logic [63:0]      successor_masks;
    logic [23:0]      dispatch_order;
    logic [POS_W-1:0] order_length;
  } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/core/dctd_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dctd_cfg_regs: configuration register file
// Holds the five dispatcher registers; flags a reload after every write to a mapped index.
// ----------------------------------------------------------------------------
module dctd_cfg_regs (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire logic [dctd_pkg::CFG_IDX_W-1:0]  wr_idx_i,
  input  wire logic [dctd_pkg::CFG_DATA_W-1:0] wr_data_i,
  output dctd_pkg::cfg_t                       cfg_o,
  output logic                                 restart_o
);
  import dctd_pkg::*;

  // reset image: everything clear, order length one
  localparam cfg_t CFG_RESET = '{
    action_counts:    '0,
    initial_blockers: '0,
    successor_masks:  '0,
    dispatch_order:   '0,
    order_length:     POS_W'(1)
  };

  cfg_t cfg_d, cfg_q;
  logic restart_d, restart_q;

  always_comb begin
    cfg_d     = cfg_q;
    restart_d = 1'b0;
    if (wr_en_i) begin
      restart_d = 1'b1;
      case (wr_idx_i)
        CFG_ACTION_COUNTS:    cfg_d.action_counts    = wr_data_i[31:0];
        CFG_INITIAL_BLOCKERS: cfg_d.initial_blockers = wr_data_i[31:0];
        CFG_SUCCESSOR_MASKS:  cfg_d.successor_masks  = wr_data_i;
        CFG_DISPATCH_ORDER:   cfg_d.dispatch_order   = wr_data_i[23:0];
        CFG_ORDER_LENGTH:     cfg_d.order_length     = wr_data_i[POS_W-1:0];
        default:              restart_d              = 1'b0; // unmapped: ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q              <= CFG_RESET;
      restart_q          <= 1'b0;
    end else begin
      cfg_q              <= cfg_d;
      restart_q          <= restart_d;
    end
  end

  assign cfg_o     = cfg_q;
  assign restart_o = restart_q;

endmodule
`default_nettype wire

FILE: rtl/core/dctd_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dctd_engine: per-set counters and single-step dispatch decision
// One lane of counters per set; request/finish resolved in one combinational step.
// ----------------------------------------------------------------------------
module dctd_engine #(
  parameter int unsigned NUM_SETS    = dctd_pkg::NUM_SETS_DEF,
  parameter int unsigned ACTION_BITS = dctd_pkg::ACTION_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire dctd_pkg::cfg_t cfg_i,
  input  wire logic           restart_i,
  input  wire logic           accept_i,
  input  wire dctd_pkg::in_t  in_data_i,
  output dctd_pkg::out_t      result_o
);
  import dctd_pkg::*;

  localparam int unsigned CNT_W  = ACTION_BITS;
  localparam int unsigned CNT_W1 = ACTION_BITS + 1;

  // per-lane status vectors, indexed by the full three-bit set id
  logic [CNT_W-1:0]   act_cnt   [MAX_SETS];
  logic [CNT_W-1:0]   issued_w  [MAX_SETS];
  logic [MAX_SETS-1:0] exhausted_v, blocked_v, full_v, last_v;
  logic [MAX_SETS-1:0] inc_issued_v, inc_finished_v, dec_blocker_v;

  logic [SET_W-1:0] current_d, current_q;
  logic [POS_W-1:0] pos_d, pos_q;

  logic [POS_W-1:0]  olen;
  logic              is_req, is_fin;
  logic              all_done, advance, grant, excess, fin_last;
  logic [SET_W-1:0]  cur_n, order_next, fset;
  logic [POS_W-1:0]  pos_n;
  logic [MASK_W-1:0] succ_mask;
  logic [7:0]        gact_wide;

  // action count per set, masked to the counter width; absent sets have none
  always_comb begin
    logic [7:0] wide;
    for (int s = 0; s < MAX_SETS; s++) begin
      wide       = 8'(cfg_i.action_counts[FIELD_W*s +: FIELD_W]);
      act_cnt[s] = (s < NUM_SETS) ? wide[CNT_W-1:0] : '0;
    end
  end

  for (genvar g = 0; g < MAX_SETS; g++) begin : g_lane
    if (g < NUM_SETS) begin : g_real
      logic [CNT_W-1:0]   issued_q, finished_q;
      logic [FIELD_W-1:0] blockers_q;

      assign issued_w[g]    = issued_q;
      assign exhausted_v[g] = (issued_q >= act_cnt[g]);
      assign blocked_v[g]   = (blockers_q != '0);
      assign full_v[g]      = (finished_q >= act_cnt[g]);
      assign last_v[g]      = ((CNT_W1'(finished_q) + CNT_W1'(1)) == CNT_W1'(act_cnt[g]));

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          issued_q   <= '0;
          finished_q <= '0;
          blockers_q <= '0;
        end else if (restart_i) begin
          issued_q   <= '0;
          finished_q <= '0;
          blockers_q <= cfg_i.initial_blockers[FIELD_W*g +: FIELD_W];
        end else begin
          if (inc_issued_v[g])   issued_q   <= issued_q + CNT_W'(1);
          if (inc_finished_v[g]) finished_q <= finished_q + CNT_W'(1);
          if (dec_blocker_v[g])  blockers_q <= blockers_q - FIELD_W'(1);
        end
      end
    end else begin : g_absent
      assign issued_w[g]    = '0;
      assign exhausted_v[g] = 1'b1;
      assign blocked_v[g]   = 1'b0;
      assign full_v[g]      = 1'b1;
      assign last_v[g]      = 1'b0;
    end
  end

  // decision
  always_comb begin
    is_req = (in_data_i.func == FUNC_REQUEST);
    is_fin = (in_data_i.func == FUNC_FINISH);

    if (cfg_i.order_length == '0)                olen = POS_W'(1);
    else if (cfg_i.order_length > POS_W'(8))     olen = POS_W'(8);
    else                                         olen = cfg_i.order_length;

    order_next = cfg_i.dispatch_order[SET_W*pos_q[2:0] +: SET_W];
    all_done   = exhausted_v[current_q] && (pos_q >= olen);
    advance    = exhausted_v[current_q] && (pos_q < olen);
    cur_n      = advance ? order_next : current_q;
    pos_n      = advance ? pos_q + POS_W'(1) : pos_q;
    grant      = !all_done && !blocked_v[cur_n] && !exhausted_v[cur_n];
    gact_wide  = 8'(issued_w[cur_n]);

    fset      = in_data_i.finished_set;
    excess    = full_v[fset];
    fin_last  = !excess && last_v[fset];
    succ_mask = cfg_i.successor_masks[MASK_W*fset +: MASK_W];

    result_o = '0;
    if (is_req) begin
      if (all_done)     result_o.status = ST_ALL_DONE;
      else if (!grant)  result_o.status = ST_BLOCKED;
      else begin
        result_o.status         = ST_GRANTED;
        result_o.granted_set    = cur_n;
        result_o.granted_action = gact_wide[ACT_W-1:0];
      end
    end else begin
      result_o.status = excess ? ST_EXCESS : ST_ACCEPTED;
    end

    for (int s = 0; s < MAX_SETS; s++) begin
      inc_issued_v[s]   = accept_i && is_req && grant && (cur_n == SET_W'(s));
      inc_finished_v[s] = accept_i && is_fin && !excess && (fset == SET_W'(s));
      dec_blocker_v[s]  = accept_i && is_fin && fin_last && succ_mask[s] && blocked_v[s];
    end

    current_d = current_q;
    pos_d     = pos_q;
    if (accept_i && is_req && !all_done) begin
      current_d = cur_n;
      pos_d     = pos_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_q <= '0;
      pos_q     <= POS_W'(1);
    end else if (restart_i) begin
      current_q <= cfg_i.dispatch_order[SET_W-1:0];
      pos_q     <= POS_W'(1);
    end else begin
      current_q <= current_d;
      pos_q     <= pos_d;
    end
  end

  // order position always names a real order slot plus one
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q >= POS_W'(1)) && (pos_q <= POS_W'(8)))
    else $error("order position out of range");

  // dispatch pointer moves only on an accepted beat or a reload
  a_cur_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!accept_i && !restart_i) |=> ($stable(current_q) && $stable(pos_q)))
    else $error("dispatch pointer moved without a beat");

  // completion reports never move the dispatch pointer
  a_fin_no_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !restart_i && is_fin) |=> ($stable(current_q) && $stable(pos_q)))
    else $error("completion moved the dispatch pointer");

endmodule
`default_nettype wire

FILE: rtl/core/dependency_counting_task_dispatcher_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dependency_counting_task_dispatcher_top: dependency-counting task dispatcher
//
// Input channel (in_*): one beat is either a request for the next action
// (func = request) or a report that an action of finished_set completed.
// Output channel (out_*): exactly one result beat per input beat, in order:
// granted (with set and action index), blocked, all dispatched, completion
// accepted, or excess completion. Set and action fields are zero unless
// the status is granted.
// Config channel (cfg_*): index selects the register, data is the value;
// always ready. Any write to a mapped index reloads all dispatcher state
// from the new values on the following cycle; input ready is low then.
// Result: registered in the result register as the input beat is taken.
// Throughput: one beat per cycle outside reloads and receiver stalls;
// set counters sit in flops, the decision is one combinational step.
// Receiver stall: the result register holds; input ready drops until the
// held beat is taken, input ready = result register empty or draining.
// Reset: registers go to their reset values, set 0 is current, all counters
// and blocker counts clear, output register empty.
// ----------------------------------------------------------------------------
module dependency_counting_task_dispatcher_top #(
  parameter int unsigned NUM_SETS    = dctd_pkg::NUM_SETS_DEF,
  parameter int unsigned ACTION_BITS = dctd_pkg::ACTION_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // request / completion beats
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire dctd_pkg::in_t                   in_data_i,
  // result beats
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output dctd_pkg::out_t                       out_data_o,
  // configuration writes
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [dctd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dctd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dctd_pkg::*;

  cfg_t cfg;
  logic restart;
  logic accept;
  out_t result;

  out_t out_d, out_q;
  logic out_valid_d, out_valid_q;

  assign cfg_ready_o = 1'b1;

  dctd_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_idx_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  // hold off input during the reload cycle and while the result is stalled
  assign in_ready_o = !restart && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  dctd_engine #(
    .NUM_SETS    (NUM_SETS),
    .ACTION_BITS (ACTION_BITS)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .result_o  (result)
  );

  // result register
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      out_d       = result;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // no beat is taken while state reloads
  a_reload_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    restart |-> !in_ready_o)
    else $error("input taken during reload");

  // grant fields are zero on every non-grant result
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status != ST_GRANTED)) |->
      ((out_data_o.granted_set == '0) && (out_data_o.granted_action == '0)))
    else $error("grant fields set on non-grant result");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.status == ST_GRANTED)  ||
                     (out_data_o.status == ST_BLOCKED)  ||
                     (out_data_o.status == ST_ALL_DONE) ||
                     (out_data_o.status == ST_ACCEPTED) ||
                     (out_data_o.status == ST_EXCESS)))
    else $error("undefined status code");

endmodule
`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the dependency-counting task dispatcher
// Drives request and completion beats with random gaps and checks every result
// beat in order against a cycle-free model of the dispatch and blocker counts.
// Configurations are loaded between phases: fixed corner cases, all-zero and
// all-one registers, random dependency graphs worked through like a thread
// pool, and fully random register images with noise traffic.
// ----------------------------------------------------------------------------
module testbench;
  import dctd_pkg::*;

  localparam int unsigned NUM_SETS       = NUM_SETS_DEF;
  localparam int unsigned ACTION_BITS    = ACTION_BITS_DEF;
  localparam logic [FIELD_W-1:0] COUNT_MASK = FIELD_W'((1 << ACTION_BITS) - 1);
  localparam int unsigned NUM_ITEMS      = 1000;
  localparam int unsigned FLOW_CAP       = 200;   // beats per dependency graph
  localparam int unsigned TAIL_CYCLES    = 4;     // settle time after last result
  localparam int unsigned WATCHDOG_LIMIT = 1000;  // cycles without any beat
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd5;

  // Expected result beats, plus the dispatcher state that produces them.
  class dispatch_scoreboard;
    logic [31:0]        action_counts;
    logic [31:0]        initial_blockers;
    logic [63:0]        successor_masks;
    logic [23:0]        dispatch_order;
    logic [POS_W-1:0]   order_length;
    logic [SET_W-1:0]   cur_set;
    logic [POS_W-1:0]   order_pos;
    logic [FIELD_W-1:0] issued   [MAX_SETS];
    logic [FIELD_W-1:0] finished [MAX_SETS];
    logic [FIELD_W-1:0] blockers [MAX_SETS];
    out_t               expected_q [$];
    int                 errors;

    function new();
      action_counts    = '0;
      initial_blockers = '0;
      successor_masks  = '0;
      dispatch_order   = '0;
      order_length     = POS_W'(1);
      errors           = 0;
      restart();
    endfunction

    function void restart();
      for (int s = 0; s < MAX_SETS; s++) begin
        issued[s]   = '0;
        finished[s] = '0;
        blockers[s] = initial_blockers[4*s +: 4];
      end
      cur_set   = dispatch_order[2:0];
      order_pos = POS_W'(1);
    endfunction

    function logic [FIELD_W-1:0] actions_in(logic [SET_W-1:0] s);
      if (s >= NUM_SETS) return '0;
      return action_counts[4*s +: 4] & COUNT_MASK;
    endfunction

    function int unsigned order_span();
      if (order_length == 0) return 1;
      if (order_length > 8) return 8;
      return order_length;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
      case (idx)
        CFG_ACTION_COUNTS:    action_counts    = v[31:0];
        CFG_INITIAL_BLOCKERS: initial_blockers = v[31:0];
        CFG_SUCCESSOR_MASKS:  successor_masks  = v;
        CFG_DISPATCH_ORDER:   dispatch_order   = v[23:0];
        CFG_ORDER_LENGTH:     order_length     = v[POS_W-1:0];
        default:              return;
      endcase
      restart();
    endfunction

    function out_t note_input(in_t beat);
      out_t               r;
      logic [SET_W-1:0]   cur;
      logic [SET_W-1:0]   s;
      logic [FIELD_W-1:0] n;
      logic [MASK_W-1:0]  mask;
      r = '0;
      if (beat.func == FUNC_REQUEST) begin
        cur = cur_set;
        if (issued[cur] >= actions_in(cur) && order_pos >= order_span()) begin
          r.status = ST_ALL_DONE;
        end else begin
          // exhausted set: step to the next order entry first
          if (issued[cur] >= actions_in(cur)) begin
            cur_set   = dispatch_order[3*order_pos +: 3];
            order_pos = order_pos + 1'b1;
            cur       = cur_set;
          end
          if (blockers[cur] != 0 || issued[cur] >= actions_in(cur)) begin
            r.status = ST_BLOCKED;
          end else begin
            r.status         = ST_GRANTED;
            r.granted_set    = cur;
            r.granted_action = issued[cur];
            issued[cur]      = (issued[cur] + 1'b1) & COUNT_MASK;
          end
        end
      end else begin
        s = beat.finished_set;
        n = actions_in(s);
        if (finished[s] >= n) begin
          r.status = ST_EXCESS;
        end else begin
          r.status    = ST_ACCEPTED;
          finished[s] = finished[s] + 1'b1;
          if (finished[s] == n) begin
            mask = successor_masks[8*s +: 8];
            for (int t = 0; t < NUM_SETS; t++) begin
              if (mask[t] && blockers[t] != 0) blockers[t] = blockers[t] - 1'b1;
            end
          end
        end
      end
      expected_q.push_back(r);
      return r;
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: status %0d set %0d action %0d",
                 $time, got.status, got.granted_set, got.granted_action);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.granted_set !== want.granted_set) begin
        errors++;
        $display("%0t: granted_set expected %0d actual %0d",
                 $time, want.granted_set, got.granted_set);
      end
      if (got.granted_action !== want.granted_action) begin
        errors++;
        $display("%0t: granted_action expected %0d actual %0d",
                 $time, want.granted_action, got.granted_action);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dispatch_scoreboard sb = new();
  int unsigned        items_sent  = 0;
  int unsigned        idle_cycles = 0;
  bit                 calm        = 1'b0;   // no gaps on either side

  dependency_counting_task_dispatcher_top #(
    .NUM_SETS    (NUM_SETS),
    .ACTION_BITS (ACTION_BITS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Sampled on the edge, before any nonblocking update lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (cfg_valid_i && cfg_ready_o) sb.apply_reg(cfg_idx_i, cfg_data_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
      end
    end
  end

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // Receiver: random stall ahead of every result beat.
  initial begin
    int unsigned gap;
    out_ready_i = 1'b0;
    @(posedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("testbench: errors");
    $finish;
  end

  // One input beat; valid stays up across back-to-back beats.
  task automatic push_item(input in_t beat, output out_t want);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    want = sb.note_input(beat);
    items_sent++;
  endtask

  task automatic issue_beat(logic f, logic [SET_W-1:0] s);
    in_t  beat;
    out_t want;
    beat.func         = f;
    beat.finished_set = s;
    push_item(beat, want);
  endtask

  function automatic in_t random_beat(int unsigned request_pct);
    in_t beat;
    beat.func         = ($urandom_range(0, 99) < request_pct) ? FUNC_REQUEST : FUNC_FINISH;
    beat.finished_set = SET_W'($urandom_range(0, 7));
    return beat;
  endfunction

  // Sender holds off until every result beat has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] v);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_regs(logic [63:0] counts, logic [63:0] blk, logic [63:0] masks,
                              logic [63:0] order, logic [63:0] len);
    drain();
    program_reg(CFG_ACTION_COUNTS, counts);
    program_reg(CFG_INITIAL_BLOCKERS, blk);
    program_reg(CFG_SUCCESSOR_MASKS, masks);
    program_reg(CFG_DISPATCH_ORDER, order);
    program_reg(CFG_ORDER_LENGTH, len);
  endtask

  // Random acyclic graph: sets ordered by a shuffle, edges among ordered sets
  // point forward, and each ordered set has one blocker per real predecessor.
  task automatic program_dag();
    logic [SET_W-1:0]   perm [MAX_SETS];
    logic [SET_W-1:0]   tmp;
    logic [31:0]        counts;
    logic [31:0]        blk;
    logic [63:0]        masks;
    logic [23:0]        order;
    logic [POS_W-1:0]   len;
    logic [FIELD_W-1:0] cnt;
    int unsigned        n;
    int unsigned        j;
    int unsigned        r;
    n = $urandom_range(1, 8);
    for (int i = 0; i < MAX_SETS; i++) perm[i] = SET_W'(i);
    for (int i = MAX_SETS - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      tmp     = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    counts = $urandom;
    blk    = $urandom;
    order  = 24'($urandom);
    masks  = '0;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 19);
      cnt = (r == 0) ? 4'd0 : (r == 1) ? 4'd15 : FIELD_W'($urandom_range(1, 4));
      order[3*i +: 3]         = perm[i];
      counts[4*perm[i] +: 4]  = cnt;
      blk[4*perm[i] +: 4]     = '0;
    end
    for (int i = 0; i < n; i++) begin
      if (counts[4*perm[i] +: 4] != 0) begin
        for (int k = i + 1; k < n; k++) begin
          if ($urandom_range(0, 2) == 0) begin
            masks[8*perm[i] + perm[k]] = 1'b1;
            blk[4*perm[k] +: 4]        = blk[4*perm[k] +: 4] + 1'b1;
          end
        end
        // edges to sets that are never dispatched do no harm
        for (int k = n; k < MAX_SETS; k++) begin
          if ($urandom_range(0, 3) == 0) masks[8*perm[i] + perm[k]] = 1'b1;
        end
      end
    end
    for (int k = n; k < MAX_SETS; k++) masks[8*perm[k] +: 8] = 8'($urandom);
    len = POS_W'(n);
    if (n == 1 && $urandom_range(0, 1) == 0) len = '0;
    if (n == 8 && $urandom_range(0, 1) == 0) len = POS_W'($urandom_range(9, 15));
    program_regs({32'($urandom), counts}, {32'($urandom), blk}, masks,
                 {40'($urandom), order}, {60'($urandom), len});
  endtask

  // Work a graph like a pool of workers: request actions, report granted
  // ones finished in random order until all is dispatched and done (or FLOW_CAP).
  task automatic run_flow(int unsigned noise_pct);
    logic [SET_W-1:0] open_sets [$];
    bit               all_done;
    in_t              beat;
    out_t             want;
    int unsigned      steps;
    int unsigned      k;
    all_done = 1'b0;
    steps    = 0;
    while (steps < FLOW_CAP && !(all_done && open_sets.size() == 0)) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        beat = random_beat(50);
      end else if (!all_done && (open_sets.size() == 0 || $urandom_range(0, 1) == 0)) begin
        beat.func         = FUNC_REQUEST;
        beat.finished_set = SET_W'($urandom_range(0, 7));
      end else begin
        k                 = $urandom_range(0, open_sets.size() - 1);
        beat.func         = FUNC_FINISH;
        beat.finished_set = open_sets[k];
        open_sets.delete(k);
      end
      push_item(beat, want);
      if (want.status == ST_GRANTED) open_sets.push_back(want.granted_set);
      if (want.status == ST_ALL_DONE) all_done = 1'b1;
      if ($urandom_range(0, 99) < 3) drain();
      steps++;
    end
  endtask

  initial begin
    in_t  beat;
    out_t want;
    int unsigned r;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_valid_i = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset image: set 0 has no actions and the order has one entry.
    issue_beat(FUNC_REQUEST, 3'd0);
    issue_beat(FUNC_FINISH, 3'd7);

    // An unmapped register index must leave the state alone.
    drain();
    program_reg(CFG_UNMAPPED, {$urandom, $urandom});
    issue_beat(FUNC_REQUEST, 3'd7);

    // Order 5, 2, 6: set 2 is empty, set 6 waits on set 5, and set 5 also
    // points at set 3, whose blocker count is already zero.
    calm = 1'b1;
    program_regs(64'h0000_0000_0110_0000, 64'h0000_0000_0100_0000,
                 64'h0000_4800_0000_0000, 64'h0000_0000_0000_0195, 64'd3);
    issue_beat(FUNC_REQUEST, 3'd0);   // grant 5.0
    issue_beat(FUNC_REQUEST, 3'd0);   // moves to the empty set
    issue_beat(FUNC_REQUEST, 3'd0);   // moves to 6, still blocked
    issue_beat(FUNC_FINISH, 3'd5);    // releases 6, saturates 3
    issue_beat(FUNC_FINISH, 3'd5);    // excess
    issue_beat(FUNC_REQUEST, 3'd0);   // grant 6.0
    issue_beat(FUNC_FINISH, 3'd6);
    issue_beat(FUNC_REQUEST, 3'd0);   // all dispatched
    issue_beat(FUNC_FINISH, 3'd3);    // never granted, no actions
    calm = 1'b0;

    // Every register at all ones; length above range clamps to eight.
    program_regs('1, '1, '1, '1, '1);
    issue_beat(FUNC_FINISH, 3'd0);
    issue_beat(FUNC_FINISH, 3'd7);
    issue_beat(FUNC_REQUEST, 3'd7);
    repeat (5) begin
      beat = random_beat(50);
      push_item(beat, want);
    end

    // Every register at zero; length zero counts as one.
    program_regs('0, '0, '0, '0, '0);
    issue_beat(FUNC_REQUEST, 3'd0);
    issue_beat(FUNC_FINISH, 3'd0);

    while (items_sent < NUM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      r    = $urandom_range(0, 9);
      if (r < 8) begin
        program_dag();
        run_flow((r < 5) ? 0 : 10);
      end else begin
        program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom});
        repeat (30) begin
          beat = random_beat(60);
          push_item(beat, want);
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
